>>> src/m11ht_pkg.sv
// shared types and constants for the mod-11 hashed bucket table
// no dependencies
`default_nettype none

package m11ht_pkg;

    localparam int NumBuckets  = 10;
    localparam int BucketSlots = 8;
    localparam int KeyW        = 27;
    localparam int BucketW     = 4;
    localparam int FillW       = $clog2(BucketSlots + 1);
    localparam int SlotW       = (BucketSlots > 1) ? $clog2(BucketSlots) : 1;
    localparam int TotalW      = $clog2(NumBuckets * BucketSlots + 1);
    localparam logic [26:0] DecMod = 27'd100000000;
    // ceil(2^30 / 10): exact quotient by ten for any 27-bit value
    localparam logic [26:0] RecipTen = 27'd107374183;
    // ceil(2^13 / 11): exact quotient by eleven for the weighted digit sum
    localparam logic [9:0]  RecipEleven = 10'd745;

    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    localparam logic [1:0] ST_DONE = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]      op;
        logic [KeyW-1:0] key;
    } req_t;

    typedef struct packed {
        logic         found;
        logic [1:0]   status;
        logic [3:0]   bucket;
        logic [3:0]   bucket_fill;
        logic         table_empty;
    } rsp_t;

    // one bucket row: a valid bit and a key word per slot
    typedef struct packed {
        logic [BucketSlots-1:0]           valid;
        logic [BucketSlots-1:0][KeyW-1:0] keys;
    } row_t;

    // check-digit map, entry at index i
    function automatic logic [BucketW-1:0] check_map(input logic [3:0] r);
        logic [BucketW-1:0] m;
        case (r)
            4'd0:    m = 4'd6;
            4'd1:    m = 4'd7;
            4'd2:    m = 4'd8;
            4'd3:    m = 4'd9;
            4'd4:    m = 4'd0;
            4'd5:    m = 4'd1;
            4'd6:    m = 4'd1;
            4'd7:    m = 4'd2;
            4'd8:    m = 4'd3;
            4'd9:    m = 4'd4;
            4'd10:   m = 4'd5;
            default: m = 4'd0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> src/mod11_hashed_chained_table.sv
// hashed keyed set: one memory row per bucket, read-modify-write per item
// depends on m11ht_pkg and m11ht_hash
// flow: each item is hashed, its bucket row is read, then updated, then the result is held until taken
// one item at a time: no new item is accepted until the result of the last one is taken
// reset: clears all row valid bits at once and the key count; key words stay undefined
// no clearing pass; the table accepts items as soon as reset ends
`default_nettype none

module mod11_hashed_chained_table
    import m11ht_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_stall,
    input  wire req_t in_data,
    output logic      out_valid,
    input  wire logic out_stall,
    output rsp_t      out_data
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_HASH  = 5'b00010,
        S_READ  = 5'b00100,
        S_WRITE = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic   hash_done;
    logic [BucketW-1:0] hash_bucket;
    logic [BucketW-1:0] bucket_reg;

    // key words in memory, valid bits in flops so reset clears them
    logic [BucketSlots-1:0][KeyW-1:0] key_mem [NumBuckets];
    logic [BucketSlots-1:0][KeyW-1:0] rd_keys_reg;
    logic [BucketSlots-1:0] valid_reg [NumBuckets];
    logic [BucketSlots-1:0] rd_valid_reg;
    logic [TotalW-1:0] total_reg, total_next;
    logic out_valid_reg;
    rsp_t rsp_reg, rsp_next;

    logic [BucketSlots-1:0] hit_vec, new_valid;
    logic hit, has_free, do_wr;
    logic [SlotW-1:0] free_idx;
    logic [FillW-1:0] fill;
    logic [1:0] st;

    m11ht_hash u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_IDLE && in_valid),
        .key    (in_data.key),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    always_comb
    begin
        hit_vec  = '0;
        has_free = 1'b0;
        free_idx = '0;
        fill     = '0;
        for (int s = 0; s < BucketSlots; s++)
        begin
            hit_vec[s] = rd_valid_reg[s] && (rd_keys_reg[s] == req_reg.key);
            fill = fill + FillW'(rd_valid_reg[s]);
        end
        for (int s = BucketSlots - 1; s >= 0; s--)
        begin
            if (!rd_valid_reg[s])
            begin
                has_free = 1'b1;
                free_idx = SlotW'(s);
            end
        end
        hit        = |hit_vec;
        new_valid  = rd_valid_reg;
        total_next = total_reg;
        st         = ST_DONE;
        do_wr      = 1'b0;
        if (req_reg.op == OP_INSERT)
        begin
            if (hit)
                st = ST_DUP;
            else if (!has_free)
                st = ST_FULL;
            else
            begin
                do_wr               = 1'b1;
                new_valid[free_idx] = 1'b1;
                fill                = fill + FillW'(1);
                total_next          = total_reg + TotalW'(1);
            end
        end
        else if (req_reg.op == OP_REMOVE && hit)
        begin
            new_valid  = rd_valid_reg & ~hit_vec;
            fill       = fill - FillW'(1);
            total_next = total_reg - TotalW'(1);
        end
        rsp_next.found       = hit;
        rsp_next.status      = st;
        rsp_next.bucket      = bucket_reg;
        rsp_next.bucket_fill = 4'(fill);
        rsp_next.table_empty = (total_next == '0);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_valid) state_next = S_HASH;
            S_HASH:  if (hash_done) state_next = S_READ;
            S_READ:  state_next = S_WRITE;
            S_WRITE: state_next = S_OUT;
            S_OUT:   if (!out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int b = 0; b < NumBuckets; b++)
                valid_reg[b] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_WRITE)
            begin
                valid_reg[bucket_reg] <= new_valid;
                total_reg             <= total_next;
                out_valid_reg         <= 1'b1;
            end
            else if (state_reg == S_OUT && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
            req_reg <= in_data;
        if (state_reg == S_HASH && hash_done)
            bucket_reg <= hash_bucket;
        if (state_reg == S_READ)
        begin
            rd_keys_reg  <= key_mem[bucket_reg];
            rd_valid_reg <= valid_reg[bucket_reg];
        end
        if (state_reg == S_WRITE)
        begin
            rsp_reg <= rsp_next;
            if (do_wr)
                key_mem[bucket_reg][free_idx] <= req_reg.key;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

`ifndef SYNTHESIS
    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT)
        else $error("result valid outside output state");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> in_stall)
        else $error("item taken while busy");
    a_bucket_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.bucket < 4'd10)
        else $error("bucket out of range");
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.bucket_fill <= 4'(BucketSlots))
        else $error("bucket fill out of range");
    a_empty_fill: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.table_empty |-> out_data.bucket_fill == 4'd0)
        else $error("empty table with nonzero fill");
`endif

endmodule

`default_nettype wire

>>> src/m11ht_hash.sv
// bucket hash: low eight decimal digits weighted and reduced mod 11
// depends on m11ht_pkg; one digit per cycle, then the bucket is registered and done is raised
`default_nettype none

module m11ht_hash
    import m11ht_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [KeyW-1:0]    key,
    output logic                    done,
    output logic [BucketW-1:0]      bucket
);

    logic [26:0] val_reg, val_next;   // digits not yet consumed
    logic [8:0]  sum_reg, sum_next;
    logic [3:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic [BucketW-1:0] bucket_reg, bucket_next;
    logic        done_reg, done_next;

    logic [53:0] prod_ten;
    logic [26:0] quo;
    logic [3:0]  digit;
    logic [2:0]  wt;
    logic [6:0]  pwt;
    logic [18:0] prod_eleven;
    logic [8:0]  quo_eleven;
    logic [3:0]  r;

    always_comb
    begin
        // divide by ten through the reciprocal, digit is what is left
        prod_ten    = 54'(val_reg) * 54'(RecipTen);
        quo         = 27'(prod_ten >> 30);
        digit       = 4'(val_reg - 27'(quo * 27'd10));
        case (step_reg)
            4'd0:    wt = 3'd2;
            4'd1:    wt = 3'd3;
            4'd2:    wt = 3'd4;
            4'd3:    wt = 3'd5;
            4'd4:    wt = 3'd6;
            4'd5:    wt = 3'd7;
            4'd6:    wt = 3'd2;
            4'd7:    wt = 3'd3;
            default: wt = 3'd0;
        endcase
        pwt         = 7'(digit) * 7'(wt);
        prod_eleven = 19'(sum_reg) * 19'(RecipEleven);
        quo_eleven  = 9'(prod_eleven >> 13);
        r           = 4'(sum_reg - 9'(quo_eleven * 9'd11));
    end

    always_comb
    begin
        val_next    = val_reg;
        sum_next    = sum_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        bucket_next = bucket_reg;
        done_next   = 1'b0;
        if (start)
        begin
            val_next  = (key >= DecMod) ? key - DecMod : key;
            sum_next  = '0;
            busy_next = 1'b1;
            step_next = 4'd0;
        end
        else if (busy_reg)
        begin
            if (step_reg < 4'd8)
            begin
                val_next  = quo;
                sum_next  = sum_reg + 9'(pwt);
                step_next = step_reg + 4'd1;
            end
            else
            begin
                bucket_next = (r == 4'd0) ? check_map(4'd0) : check_map(4'd11 - r);
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg    <= val_next;
        sum_reg    <= sum_next;
        bucket_reg <= bucket_next;
    end

    assign done   = done_reg;
    assign bucket = bucket_reg;

endmodule

`default_nettype wire

>>> dv/testbench.sv
// testbench for the mod-11 hashed bucket table: directed and random find/insert/remove items
// depends on m11ht_pkg and the mod11_hashed_chained_table rtl
`default_nettype none

module testbench
    import m11ht_pkg::*;
();

    class table_scoreboard;
        logic [KeyW-1:0] keys [NumBuckets*BucketSlots];
        bit              used [NumBuckets*BucketSlots];
        int              stored;
        rsp_t            pending[$];
        int              errors;

        function new();
            foreach (used[i]) used[i] = 0;
            stored = 0;
            errors = 0;
        endfunction

        function logic [3:0] bucket_for(logic [KeyW-1:0] key);
            int v, acc, r;
            int wts[8] = '{2, 3, 4, 5, 6, 7, 2, 3};
            int map[11] = '{6, 7, 8, 9, 0, 1, 1, 2, 3, 4, 5};
            v = key % 100000000;
            acc = 0;
            for (int d = 0; d < 8; d++)
            begin
                acc += (v % 10) * wts[d];
                v /= 10;
            end
            r = acc % 11;
            return 4'((r == 0) ? map[0] : map[11 - r]);
        endfunction

        function void note_request(req_t req);
            rsp_t rsp;
            int base, hit, free_slot, fill;
            rsp = '0;
            rsp.bucket = bucket_for(req.key);
            base = rsp.bucket * BucketSlots;
            hit = -1;
            free_slot = -1;
            fill = 0;
            for (int s = 0; s < BucketSlots; s++)
            begin
                if (used[base+s])
                begin
                    fill++;
                    if (hit < 0 && keys[base+s] == req.key) hit = s;
                end
                else if (free_slot < 0)
                    free_slot = s;
            end
            if (req.op == OP_INSERT)
            begin
                if (hit >= 0)
                    rsp.status = ST_DUP;
                else if (free_slot < 0)
                    rsp.status = ST_FULL;
                else
                begin
                    keys[base+free_slot] = req.key;
                    used[base+free_slot] = 1;
                    fill++;
                    stored++;
                end
            end
            else if (req.op == OP_REMOVE && hit >= 0)
            begin
                used[base+hit] = 0;
                fill--;
                stored--;
            end
            rsp.found = (hit >= 0);
            rsp.bucket_fill = 4'(fill);
            rsp.table_empty = (stored == 0);
            pending = {pending, rsp};
        endfunction

        function void check_response(rsp_t got);
            rsp_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result %p", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.found !== exp.found)
            begin
                $error("found: expected %0d actual %0d", exp.found, got.found);
                errors++;
            end
            if (got.status !== exp.status)
            begin
                $error("status: expected %0d actual %0d", exp.status, got.status);
                errors++;
            end
            if (got.bucket !== exp.bucket)
            begin
                $error("bucket: expected %0d actual %0d", exp.bucket, got.bucket);
                errors++;
            end
            if (got.bucket_fill !== exp.bucket_fill)
            begin
                $error("bucket_fill: expected %0d actual %0d", exp.bucket_fill,
                       got.bucket_fill);
                errors++;
            end
            if (got.table_empty !== exp.table_empty)
            begin
                $error("table_empty: expected %0d actual %0d", exp.table_empty,
                       got.table_empty);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_stall;
    req_t in_data = '0;
    logic out_valid;
    logic out_stall = 0;
    rsp_t out_data;

    table_scoreboard sb = new();
    logic [KeyW-1:0] key_pool[$];
    bit hold_output = 0;
    longint cycles = 0;

    mod11_hashed_chained_table i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data)
    );

    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            sb.note_request(in_data);

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_response(out_data);

    // receiver stall pattern, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_output)
            out_stall <= 1;
        else
            case (cycles / 3000 % 3)
                0: out_stall <= 0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 1) == 0);
            endcase
    end

    // one item, held until accepted
    task automatic send_item(logic [1:0] op, logic [KeyW-1:0] key);
        in_valid <= 1;
        in_data <= '{op: op, key: key};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_cycles(int n);
        in_valid <= 0;
        repeat (n) @(posedge clk);
    endtask

    function automatic logic [KeyW-1:0] pick_key();
        int sel;
        logic [KeyW-1:0] k;
        sel = $urandom_range(0, 9);
        if (sel < 6 && key_pool.size() > 0)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (sel == 9)
            k = KeyW'($urandom);
        else
            k = KeyW'($urandom_range(0, 99999999));
        if (key_pool.size() < 120) key_pool = {key_pool, k};
        return k;
    endfunction

    initial
    begin
        int burst;
        logic [1:0] op;
        int fill_keys[8] = '{14, 28, 31, 45, 59, 62, 93, 100000014};
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: field extremes, every op, duplicate, absent remove, unused op
        send_item(OP_FIND, 0);
        send_item(OP_REMOVE, 0);
        send_item(OP_INSERT, 0);
        send_item(OP_INSERT, 0);
        send_item(OP_FIND, 0);
        send_item(OP_INSERT, 99999999);
        send_item(OP_INSERT, 27'h7FFFFFF);
        send_item(2'd3, 27'h7FFFFFF);
        send_item(OP_REMOVE, 27'h7FFFFFF);
        send_item(OP_INSERT, 100000000);
        // fill bucket of key 0 past capacity: these keys have a weighted sum of 0 mod 11
        foreach (fill_keys[i])
            send_item(OP_INSERT, KeyW'(fill_keys[i]));
        send_item(OP_REMOVE, 0);
        send_item(OP_REMOVE, 100000000);
        send_item(OP_REMOVE, 99999999);
        idle_cycles(0);

        for (int n = 0; n < 1950; )
        begin
            burst = $urandom_range(1, 30);
            for (int b = 0; b < burst && n < 1950; b++, n++)
            begin
                op = $urandom_range(0, 9) < 5 ? OP_INSERT : 2'($urandom_range(0, 3));
                send_item(op, pick_key());
            end
            if (n % 400 < burst)
            begin
                // wait for the block to drain
                idle_cycles(1);
                while (sb.pending.size() > 0) @(posedge clk);
            end
            if (n % 700 < burst && !hold_output)
            begin
                fork
                    begin
                        hold_output = 1;
                        repeat (300) @(posedge clk);
                        hold_output = 0;
                    end
                join_none
            end
            if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 12));
        end
        in_valid <= 0;
        while (sb.pending.size() > 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire

>>> sim.f
src/m11ht_pkg.sv
src/m11ht_hash.sv
src/mod11_hashed_chained_table.sv
dv/testbench.sv
